[design/hbs_pkg.sv]
// Shared widths, reset values and the command word for the histogram split search.
// No dependencies; every other design file imports this package.
package hbs_pkg;

  // Field widths of the streamed bins, the internal arithmetic and the result.
  localparam int CNT_W  = 25;
  localparam int SUM_W  = 48;
  localparam int LSUM_W = 64;
  localparam int MAG_W  = 64;
  localparam int PROD_W = 128;
  localparam int TERM_W = 112;
  localparam int SUMT_W = 113;
  localparam int LOSS_W = 80;
  localparam int GAIN_W = 63;
  localparam int BIN_W  = 9;
  localparam int IDX_W  = 16;

  // Register port geometry.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register map and reset values.
  localparam logic [CFG_AW-3:0] REG_MIN_LEAF   = '0;
  localparam logic [CNT_W-1:0]  MIN_LEAF_RESET = 25'd256;

  // Work handed from the front end to the evaluation engine.
  typedef struct packed {
    logic               do_loss;
    logic               do_eval;
    logic               do_emit;
    logic [SUM_W-1:0]   tot_mag;
    logic [CNT_W-1:0]   tot_cnt;
    logic [MAG_W-1:0]   l_mag;
    logic [CNT_W-1:0]   l_cnt;
    logic [MAG_W-1:0]   r_mag;
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   index;
  } cmd_t;

endpackage

[design/hbs_in_if.sv]
// Bin channel: valid/ready handshake carrying one histogram bin per word.
// Depends on hbs_pkg for the field widths.
interface hbs_in_if import hbs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CNT_W-1:0]        bin_count;
  logic signed [SUM_W-1:0] bin_sum;
  logic [CNT_W-1:0]        total_count;
  logic signed [SUM_W-1:0] total_sum;
  logic                    last_bin;

  modport source (output valid, bin_count, bin_sum, total_count, total_sum, last_bin,
                  input ready);
  modport sink (input valid, bin_count, bin_sum, total_count, total_sum, last_bin,
                output ready);
endinterface

[design/hbs_out_if.sv]
// Result channel: valid/ready handshake carrying the best split of one histogram.
// Depends on hbs_pkg for the field widths.
interface hbs_out_if import hbs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [BIN_W-1:0] best_bin;
  logic [GAIN_W-1:0]       best_gain;

  modport source (output valid, best_bin, best_gain, input ready);
  modport sink (input valid, best_bin, best_gain, output ready);
endinterface

[design/histogram_best_split_search.sv]
// Best split search over a streamed feature histogram. Bins are taken by a
// front end that keeps the running left totals and passes each candidate bin
// through a two-word command queue to an evaluation engine, so the input
// stalls only when that queue is full. The engine computes each squared-error
// term on one shared unit: a 32x32 multiplier for the square and a
// two-bit-per-cycle divider. A candidate bin takes two terms plus the gain
// and compare steps, and the first bin of a histogram one more term for the
// total. The last bin yields one word after the queued work ahead of it.
// min_leaf_count is written through the register port at byte address 0 and
// resets to 256. Depends on hbs_pkg, the channel interfaces, hbs_front,
// hbs_queue and hbs_back.
module histogram_best_split_search import hbs_pkg::*; #(
  parameter int MAX_BINS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  hbs_in_if.sink            in_ch,
  hbs_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [CNT_W-1:0] min_leaf_r;
  logic             reg_hit;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  cmd_t             q_cmd;
  cmd_t             q_head;

  // Register port.
  assign pready  = 1'b1;
  assign reg_hit = paddr[CFG_AW-1:2] == REG_MIN_LEAF;
  assign prdata  = reg_hit ? CFG_DW'(min_leaf_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_leaf_r <= MIN_LEAF_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      min_leaf_r <= pwdata[CNT_W-1:0];
    end
  end

  hbs_front #(.MAX_BINS(MAX_BINS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .min_leaf (min_leaf_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  hbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  hbs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_best_bin  (out_ch.best_bin),
    .out_best_gain (out_ch.best_gain)
  );

endmodule

[design/hbs_term.sv]
// Term unit: floor(floor(m*m / c) / 2^16) using one 32x32 multiplier and a
// two-bit-per-cycle restoring divider. Depends on hbs_pkg.
module hbs_term import hbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MAG_W-1:0]  m,
  input  logic [CNT_W-1:0]  c,
  output logic              busy,
  output logic              done,
  output logic [TERM_W-1:0] res
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_MUL  = 2'd1;
  localparam logic [1:0] T_DIV  = 2'd2;

  logic [1:0]        state_r;
  logic [1:0]        step_r;
  logic [5:0]        cnt_r;
  logic              done_r;
  logic [MAG_W-1:0]  m_r;
  logic [CNT_W-1:0]  c_r;
  logic [63:0]       prod_r;
  logic [PROD_W-1:0] work_r;
  logic [CNT_W-1:0]  rem_r;

  logic [31:0]       opa;
  logic [31:0]       opb;
  logic [PROD_W-1:0] addend;
  logic [CNT_W:0]    r1;
  logic [CNT_W:0]    r2;
  logic [CNT_W:0]    s1;
  logic [CNT_W:0]    s2;
  logic              ge1;
  logic              ge2;

  // Partial products of the square: low*low, low*high, high*high.
  always_comb begin
    opa = (step_r == 2'd2) ? m_r[63:32] : m_r[31:0];
    opb = (step_r == 2'd0) ? m_r[31:0] : m_r[63:32];
    case (step_r)
      2'd1:    addend = PROD_W'(prod_r);
      2'd2:    addend = PROD_W'(prod_r) << 33;
      2'd3:    addend = PROD_W'(prod_r) << 64;
      default: addend = '0;
    endcase
  end

  // Two restoring division steps per cycle; quotient bits shift into the word.
  always_comb begin
    r1  = {rem_r, work_r[PROD_W-1]};
    ge1 = r1 >= {1'b0, c_r};
    s1  = ge1 ? (r1 - {1'b0, c_r}) : r1;
    r2  = {s1[CNT_W-1:0], work_r[PROD_W-2]};
    ge2 = r2 >= {1'b0, c_r};
    s2  = ge2 ? (r2 - {1'b0, c_r}) : r2;
  end

  // Sequencer for square then divide.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      done_r  <= 1'b0;
      step_r  <= '0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        T_IDLE: begin
          if (start) begin
            m_r    <= m;
            c_r    <= c;
            work_r <= '0;
            step_r <= '0;
            if (c == '0) begin
              done_r <= 1'b1;
            end else begin
              state_r <= T_MUL;
            end
          end
        end
        T_MUL: begin
          if (step_r != 2'd3) begin
            prod_r <= opa * opb;
          end
          work_r <= work_r + addend;
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) begin
            state_r <= T_DIV;
            cnt_r   <= '0;
            rem_r   <= '0;
          end
        end
        T_DIV: begin
          work_r <= {work_r[PROD_W-3:0], ge1, ge2};
          rem_r  <= s2[CNT_W-1:0];
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            state_r <= T_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign busy = state_r != T_IDLE;
  assign done = done_r;
  assign res  = work_r[PROD_W-1:16];

endmodule

[design/hbs_queue.sv]
// Two-entry command queue between the bin front end and the evaluation engine.
// Depends on hbs_pkg for cmd_t.
module hbs_queue import hbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign head  = mem_r[rp_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("command pushed into a full queue");

endmodule

[design/hbs_front.sv]
// Front end: accepts bins, keeps running left totals and decides per bin
// whether a split is evaluated. Depends on hbs_pkg and hbs_in_if.
module hbs_front import hbs_pkg::*; #(
  parameter int MAX_BINS = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  hbs_in_if.sink           in_ch,
  input  logic [CNT_W-1:0] min_leaf,
  input  logic             q_full,
  output logic             q_push,
  output cmd_t             q_cmd
);

  localparam int POS_W = $clog2(MAX_BINS + 1);
  localparam logic signed [LSUM_W-1:0] LSUM_MAX = {1'b0, {(LSUM_W-1){1'b1}}};
  localparam logic signed [LSUM_W-1:0] LSUM_MIN = {1'b1, {(LSUM_W-1){1'b0}}};

  logic [POS_W-1:0]         pos_r;
  logic                     stop_r;
  logic [CNT_W-1:0]         lcnt_r;
  logic signed [LSUM_W-1:0] lsum_r;
  logic [CNT_W-1:0]         hcnt_r;
  logic signed [SUM_W-1:0]  hsum_r;

  logic                     acc;
  logic                     first;
  logic [CNT_W-1:0]         ht_cnt;
  logic signed [SUM_W-1:0]  ht_sum;
  logic [CNT_W:0]           cnt_sum;
  logic [CNT_W-1:0]         lc_new;
  logic signed [LSUM_W-1:0] bs64;
  logic signed [LSUM_W-1:0] raw;
  logic                     ovf;
  logic signed [LSUM_W-1:0] ls_new;
  logic signed [LSUM_W-1:0] ht64;
  logic [LSUM_W:0]          diff;
  logic [LSUM_W:0]          diff_neg;
  logic [MAG_W-1:0]         rmag;
  logic [MAG_W-1:0]         lmag;
  logic [SUM_W-1:0]         tmag;
  logic [CNT_W:0]           rc;
  logic                     cand;
  logic                     below_l;
  logic                     right_low;
  logic                     do_eval;
  logic                     set_stop;

  assign in_ch.ready = !q_full;
  assign acc   = in_ch.valid && !q_full;
  assign first = pos_r == '0;

  // Totals are sampled from the first bin of a histogram.
  assign ht_cnt = first ? in_ch.total_count : hcnt_r;
  assign ht_sum = first ? in_ch.total_sum : hsum_r;

  // Saturating left count and left sum.
  always_comb begin
    cnt_sum = {1'b0, lcnt_r} + {1'b0, in_ch.bin_count};
    lc_new  = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
    bs64    = LSUM_W'(in_ch.bin_sum);
    raw     = lsum_r + bs64;
    ovf     = (lsum_r[LSUM_W-1] == bs64[LSUM_W-1]) && (raw[LSUM_W-1] != lsum_r[LSUM_W-1]);
    if (ovf) begin
      ls_new = lsum_r[LSUM_W-1] ? LSUM_MIN : LSUM_MAX;
    end else begin
      ls_new = raw;
    end
  end

  // Magnitudes of both sides and of the total.
  always_comb begin
    ht64     = LSUM_W'(ht_sum);
    diff     = {ht64[LSUM_W-1], ht64} - {ls_new[LSUM_W-1], ls_new};
    diff_neg = ~diff + 1'b1;
    rmag     = diff[LSUM_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
    lmag     = ls_new[LSUM_W-1] ? (~ls_new + 1'b1) : ls_new;
    tmag     = ht_sum[SUM_W-1] ? (~ht_sum + 1'b1) : ht_sum;
  end

  // Candidate classification for this bin.
  always_comb begin
    rc        = {1'b0, ht_cnt} - {1'b0, lc_new};
    cand      = !stop_r && (pos_r < POS_W'(MAX_BINS - 1)) && !in_ch.last_bin;
    below_l   = lc_new < min_leaf;
    right_low = rc[CNT_W] || (rc[CNT_W-1:0] < min_leaf);
    do_eval   = cand && !below_l && !right_low;
    set_stop  = cand && !below_l && right_low;
  end

  // Command word for the engine.
  always_comb begin
    q_cmd.do_loss = first;
    q_cmd.do_eval = do_eval;
    q_cmd.do_emit = in_ch.last_bin;
    q_cmd.tot_mag = tmag;
    q_cmd.tot_cnt = ht_cnt;
    q_cmd.l_mag   = lmag;
    q_cmd.l_cnt   = lc_new;
    q_cmd.r_mag   = rmag;
    q_cmd.r_cnt   = rc[CNT_W-1:0];
    q_cmd.index   = IDX_W'(pos_r);
  end

  assign q_push = acc && (first || in_ch.last_bin || do_eval);

  // Running scan state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      stop_r <= 1'b0;
      lcnt_r <= '0;
      lsum_r <= '0;
      hcnt_r <= '0;
      hsum_r <= '0;
    end else if (acc) begin
      if (first) begin
        hcnt_r <= in_ch.total_count;
        hsum_r <= in_ch.total_sum;
      end
      if (in_ch.last_bin) begin
        pos_r  <= '0;
        stop_r <= 1'b0;
        lcnt_r <= '0;
        lsum_r <= '0;
      end else begin
        lcnt_r <= lc_new;
        lsum_r <= ls_new;
        if (set_stop) stop_r <= 1'b1;
        if (pos_r < POS_W'(MAX_BINS)) pos_r <= pos_r + 1'b1;
      end
    end
  end

endmodule

[design/hbs_back.sv]
// Evaluation engine: computes loss terms on the shared term unit, tracks the
// best gain and drives the result register. Depends on hbs_pkg and hbs_term.
module hbs_back import hbs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  cmd_t                    q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [BIN_W-1:0] out_best_bin,
  output logic [GAIN_W-1:0]       out_best_gain
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LOSS_GO  = 4'd1;
  localparam logic [3:0] S_LOSS_WT  = 4'd2;
  localparam logic [3:0] S_LEFT_GO  = 4'd3;
  localparam logic [3:0] S_LEFT_WT  = 4'd4;
  localparam logic [3:0] S_RIGHT_GO = 4'd5;
  localparam logic [3:0] S_RIGHT_WT = 4'd6;
  localparam logic [3:0] S_SUB      = 4'd7;
  localparam logic [3:0] S_CMP      = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  logic [3:0]        state_r;
  cmd_t              cur_r;
  logic [LOSS_W-1:0] loss_r;
  logic [SUMT_W-1:0] sum_r;
  logic              gain_ok_r;
  logic [GAIN_W-1:0] gain_r;
  logic [GAIN_W-1:0] best_gain_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic              best_none_r;
  logic              ov_r;
  logic [BIN_W-1:0]  ob_r;
  logic [GAIN_W-1:0] og_r;

  logic              term_start;
  logic [MAG_W-1:0]  term_m;
  logic [CNT_W-1:0]  term_c;
  logic              term_busy;
  logic              term_done;
  logic [TERM_W-1:0] term_res;
  logic [SUMT_W-1:0] loss_ext;
  logic [SUMT_W-1:0] diff;
  logic              load;

  hbs_term u_term (
    .clk   (clk),
    .rst_n (rst_n),
    .start (term_start),
    .m     (term_m),
    .c     (term_c),
    .busy  (term_busy),
    .done  (term_done),
    .res   (term_res)
  );

  // Operand selection for the term unit.
  always_comb begin
    term_start = 1'b0;
    term_m     = cur_r.l_mag;
    term_c     = cur_r.l_cnt;
    case (state_r)
      S_LOSS_GO: begin
        term_start = 1'b1;
        term_m     = MAG_W'(cur_r.tot_mag);
        term_c     = cur_r.tot_cnt;
      end
      S_LEFT_GO: begin
        term_start = 1'b1;
      end
      S_RIGHT_GO: begin
        term_start = 1'b1;
        term_m     = cur_r.r_mag;
        term_c     = cur_r.r_cnt;
      end
      default: term_start = 1'b0;
    endcase
  end

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign loss_ext = SUMT_W'(loss_r);
  assign diff     = sum_r - loss_ext;
  assign load     = (state_r == S_EMIT) && (!ov_r || out_ready);

  // Engine sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loss_r      <= '0;
      best_gain_r <= '0;
      best_idx_r  <= '0;
      best_none_r <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cur_r <= q_head;
            if (q_head.do_loss) begin
              state_r <= S_LOSS_GO;
            end else if (q_head.do_eval) begin
              state_r <= S_LEFT_GO;
            end else if (q_head.do_emit) begin
              state_r <= S_EMIT;
            end
          end
        end
        S_LOSS_GO:  state_r <= S_LOSS_WT;
        S_LOSS_WT: begin
          if (term_done) begin
            loss_r <= term_res[LOSS_W-1:0];
            if (cur_r.do_eval) begin
              state_r <= S_LEFT_GO;
            end else if (cur_r.do_emit) begin
              state_r <= S_EMIT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_LEFT_GO:  state_r <= S_LEFT_WT;
        S_LEFT_WT: begin
          if (term_done) begin
            sum_r   <= SUMT_W'(term_res);
            state_r <= S_RIGHT_GO;
          end
        end
        S_RIGHT_GO: state_r <= S_RIGHT_WT;
        S_RIGHT_WT: begin
          if (term_done) begin
            sum_r   <= sum_r + SUMT_W'(term_res);
            state_r <= S_SUB;
          end
        end
        // Gain over the unsplit loss, saturated to the result width.
        S_SUB: begin
          gain_ok_r <= sum_r > loss_ext;
          gain_r    <= (|diff[SUMT_W-1:GAIN_W]) ? '1 : diff[GAIN_W-1:0];
          state_r   <= S_CMP;
        end
        S_CMP: begin
          if (gain_ok_r && (gain_r > best_gain_r)) begin
            best_gain_r <= gain_r;
            best_idx_r  <= cur_r.index;
            best_none_r <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        S_EMIT: begin
          if (load) begin
            best_gain_r <= '0;
            best_none_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_r <= best_none_r ? '1 : best_idx_r[BIN_W-1:0];
      og_r <= best_gain_r;
    end
  end

  assign out_valid     = ov_r;
  assign out_best_bin  = ob_r;
  assign out_best_gain = og_r;

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    best_none_r |-> best_gain_r == '0)
    else $error("no split recorded but gain is non-zero");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside the emit step");

  a_term_free: assert property (@(posedge clk) disable iff (!rst_n)
    term_start |-> !term_busy)
    else $error("term unit started while busy");

endmodule

[verif/tb_histogram_best_split_search.sv]
// Testbench for the histogram best split search: drives streamed bins and checks best splits.
// Depends on hbs_pkg, the two channel interfaces and the histogram_best_split_search top level.
`timescale 1ns / 1ps

module tb_histogram_best_split_search;
  import hbs_pkg::*;

  localparam int                MAX_BINS_TB = 256;
  localparam int                CMAX_CNT    = (1 << CNT_W) - 1;
  localparam logic [GAIN_W-1:0] GAIN_SAT    = {GAIN_W{1'b1}};
  localparam int                WATCH_LIMIT = 20000;
  localparam int                ITEM_BUDGET = 1850;

  // One bin word as it is sent.
  typedef struct {
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        tcnt;
    logic signed [SUM_W-1:0] tsum;
    logic                    last;
  } bin_word_t;

  // One best split as it is expected.
  typedef struct {
    logic [BIN_W-1:0]  bin;
    logic [GAIN_W-1:0] gain;
  } split_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;
  logic pready;

  hbs_in_if  in_ch ();
  hbs_out_if out_ch ();

  histogram_best_split_search dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bin_word_t pending_bins[$];
  split_t    expected_splits[$];
  int        errors    = 0;
  int        sent      = 0;
  bit        no_idle   = 0;
  int        in_gap    = 0;
  int        out_gap   = 0;
  int        quiet_cyc = 0;

  // Predictor state and its copy of the register.
  logic [CNT_W-1:0]        min_leaf;
  logic [CNT_W-1:0]        run_cnt;
  logic signed [63:0]      run_sum;
  logic [CNT_W-1:0]        hist_cnt;
  logic signed [SUM_W-1:0] hist_sum;
  logic [TERM_W-1:0]       parent_loss;
  logic [GAIN_W-1:0]       top_gain;
  int                      top_index;
  int                      bin_pos;
  bit                      scan_done;

  // Clock and the single reset.
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_ch.valid = 0; in_ch.bin_count = '0; in_ch.bin_sum = '0;
    in_ch.total_count = '0; in_ch.total_sum = '0; in_ch.last_bin = 0;
    out_ch.ready = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
  end

  // Squared term: floor(floor(m*m / c) / 2^16), zero for an empty side.
  function automatic logic [TERM_W-1:0] sq_over_count(logic [63:0] m, logic [CNT_W-1:0] c);
    logic [127:0] prod;
    logic [127:0] quo;
    if (c == 0) return '0;
    prod = {64'd0, m} * {64'd0, m};
    quo  = prod / {103'd0, c};
    return quo[127:16];
  endfunction

  function automatic logic [63:0] abs65(logic signed [64:0] v);
    logic signed [64:0] a;
    a = (v < 0) ? -v : v;
    return a[63:0];
  endfunction

  function automatic void clear_scan();
    run_cnt   = '0;
    run_sum   = '0;
    top_gain  = '0;
    top_index = -1;
    bin_pos   = 0;
    scan_done = 0;
  endfunction

  // Gain of splitting after the current bin, kept if it beats the best so far.
  function automatic void score_split(int index);
    logic signed [26:0]  right_cnt;
    logic signed [64:0]  right_diff;
    logic [TERM_W-1:0]   tl, tr;
    logic [SUMT_W-1:0]   s, diff;
    logic [GAIN_W-1:0]   g;
    right_cnt = $signed({2'b0, hist_cnt}) - $signed({2'b0, run_cnt});
    if (run_cnt < min_leaf) return;
    if (right_cnt < $signed({2'b0, min_leaf})) begin
      scan_done = 1;
      return;
    end
    right_diff = 65'(hist_sum) - 65'(run_sum);
    tl = sq_over_count(abs65(65'(run_sum)), run_cnt);
    tr = sq_over_count(abs65(right_diff), right_cnt[CNT_W-1:0]);
    s  = {1'b0, tl} + {1'b0, tr};
    if (s <= {1'b0, parent_loss}) return;
    diff = s - {1'b0, parent_loss};
    g = (diff > {50'd0, GAIN_SAT}) ? GAIN_SAT : diff[GAIN_W-1:0];
    if (g > top_gain) begin
      top_gain  = g;
      top_index = index;
    end
  endfunction

  // Advance the predictor by one accepted bin word.
  function automatic void track_bin(bin_word_t w);
    logic [CNT_W:0]     csum;
    logic signed [64:0] ssum;
    split_t             r;
    if (bin_pos == 0) begin
      hist_cnt    = w.tcnt;
      hist_sum    = w.tsum;
      parent_loss = sq_over_count(abs65(65'(w.tsum)), w.tcnt);
    end
    if (w.last) begin
      r.bin  = top_index[BIN_W-1:0];
      r.gain = top_gain;
      expected_splits = {expected_splits, r};
      clear_scan();
      return;
    end
    csum    = {1'b0, run_cnt} + {1'b0, w.cnt};
    run_cnt = (csum > CMAX_CNT) ? CNT_W'(CMAX_CNT) : csum[CNT_W-1:0];
    ssum    = 65'(run_sum) + 65'(w.sum);
    if (ssum > 65'sh0_7FFF_FFFF_FFFF_FFFF) run_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (ssum < -65'sh0_8000_0000_0000_0000) run_sum = 64'sh8000_0000_0000_0000;
    else run_sum = ssum[63:0];
    if (!scan_done && bin_pos < MAX_BINS_TB - 1) score_split(bin_pos);
    if (bin_pos < MAX_BINS_TB) bin_pos++;
  endfunction

  // Bin driver: feeds the channel from the pending queue with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_bin('{in_ch.bin_count, in_ch.bin_sum, in_ch.total_count,
                    in_ch.total_sum, in_ch.last_bin});
        sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 0;
        end else if (pending_bins.size() > 0) begin
          bin_word_t w;
          w = pending_bins.pop_front();
          in_ch.valid       <= 1;
          in_ch.bin_count   <= w.cnt;
          in_ch.bin_sum     <= w.sum;
          in_ch.total_count <= w.tcnt;
          in_ch.total_sum   <= w.tsum;
          in_ch.last_bin    <= w.last;
          if (!no_idle && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 5);
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // Result monitor: random stalls on ready, compares each word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_splits.size() == 0) begin
          $display("%0t: unexpected result bin %0d gain %0h", $time,
                   $signed(out_ch.best_bin), out_ch.best_gain);
          errors++;
        end else begin
          split_t e;
          e = expected_splits.pop_front();
          if (out_ch.best_bin !== e.bin) begin
            $display("%0t: best_bin expected %0d actual %0d", $time,
                     $signed(e.bin), $signed(out_ch.best_bin));
            errors++;
          end
          if (out_ch.best_gain !== e.gain) begin
            $display("%0t: best_gain expected %0h actual %0h", $time,
                     e.gain, out_ch.best_gain);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
        if (!no_idle && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 5);
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cyc <= 0;
    else quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= WATCH_LIMIT) begin
      $display("histogram_best_split_search test failed");
      $finish;
    end
  end

  // Register write over the APB-style port; the copy follows the write.
  task automatic write_min_leaf(logic [CNT_W-1:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {REG_MIN_LEAF, 2'b00}; pwdata <= CFG_DW'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    min_leaf = v;
  endtask

  // Wait until every word has gone through and the block is quiet.
  task automatic drain();
    while (pending_bins.size() != 0 || in_ch.valid || expected_splits.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic signed [SUM_W-1:0] rand_sum(int shift);
    logic [63:0] v;
    v = {$urandom, $urandom};
    return $signed(v[SUM_W-1:0]) >>> shift;
  endfunction

  function automatic logic [CNT_W-1:0] rand_cnt_full();
    if ($urandom_range(0, 15) == 0) return 25'd16777216;
    return CNT_W'($urandom_range(0, 16777215));
  endfunction

  function automatic void push_word(logic [CNT_W-1:0] c, logic signed [SUM_W-1:0] s,
                                    logic [CNT_W-1:0] tc, logic signed [SUM_W-1:0] ts,
                                    logic last);
    bin_word_t w;
    w = '{c, s, tc, ts, last};
    pending_bins = {pending_bins, w};
  endfunction

  // One histogram: consistent totals with counts around the leaf minimum, or noise.
  function automatic void add_histogram(int nbins, bit noise);
    logic [CNT_W-1:0]        cnts[$];
    logic signed [SUM_W-1:0] sums[$];
    longint                  tc;
    logic signed [63:0]      ts;
    int                      lim;
    lim = 3 * int'(min_leaf) / ((nbins > 1) ? nbins - 1 : 1) + 1;
    if (lim > 16777216) lim = 16777216;
    tc = 0; ts = 0;
    for (int i = 0; i < nbins; i++) begin
      if (noise || $urandom_range(0, 15) == 0) begin
        cnts = {cnts, rand_cnt_full()};
        sums = {sums, rand_sum(noise ? $urandom_range(0, 47) : $urandom_range(12, 47))};
      end else begin
        cnts = {cnts, CNT_W'($urandom_range(0, lim))};
        sums = {sums, rand_sum($urandom_range(12, 44))};
      end
      if (i < nbins - 1) begin
        tc += cnts[i];
        ts += 64'(sums[i]);
      end
    end
    if (tc > 16777216) tc = 16777216;
    if (ts > 64'sh7FFF_FFFF_FFFF) ts = 64'sh7FFF_FFFF_FFFF;
    if (ts < -64'sh8000_0000_0000) ts = -64'sh8000_0000_0000;
    for (int i = 0; i < nbins; i++) begin
      if (i == 0 && !noise)
        push_word(cnts[i], sums[i], CNT_W'(tc), ts[SUM_W-1:0], i == nbins - 1);
      else
        push_word(cnts[i], sums[i], rand_cnt_full(), rand_sum(0), i == nbins - 1);
    end
  endfunction

  // Stimulus: directed histograms, then random phases under several leaf minimums.
  initial begin
    int queued;
    int phase_items;
    logic [CNT_W-1:0] leaf_set[8];
    min_leaf = MIN_LEAF_RESET;
    clear_scan();
    hist_cnt = '0; hist_sum = '0; parent_loss = '0;
    queued = 0;
    @(posedge rst_n);
    repeat (3) @(posedge clk);

    // Directed part under the reset minimum.
    // A histogram that is only a last bin.
    push_word(25'd0, 48'sd0, 25'd0, 48'sd0, 1);
    // Extreme counts and sums; the left count saturates on the second bin.
    push_word(25'd16777216, 48'sh7FFF_FFFF_FFFF, 25'd16777216, 48'sh7FFF_FFFF_FFFF, 0);
    push_word(25'd16777216, -48'sh8000_0000_0000, 25'd0, 48'sd0, 0);
    push_word(25'd1, 48'sd1, 25'd0, 48'sd0, 0);
    push_word(25'd16777216, -48'sh8000_0000_0000, 25'd16777216, 48'sh7FFF_FFFF_FFFF, 1);
    // Zero total count, so the right side is negative at once.
    push_word(25'd300, 48'sh1_0000, 25'd0, 48'sh5_0000, 0);
    push_word(25'd300, -48'sh1_0000, 25'd0, 48'sd0, 0);
    push_word(25'd0, 48'sd0, 25'd0, 48'sd0, 1);
    // A clean split between two groups, then a left side that is too thin.
    push_word(25'd400, 48'sh400_0000, 25'd800, 48'sh0, 0);
    push_word(25'd400, -48'sh400_0000, 25'd0, 48'sd0, 0);
    push_word(25'd0, 48'sd0, 25'd0, 48'sd0, 1);
    push_word(25'd10, -48'sh7_0000, 25'd1000, -48'sh20_0000, 0);
    push_word(25'd500, -48'sh10_0000, 25'd0, 48'sd0, 0);
    push_word(25'd490, -48'sh9_0000, 25'd0, 48'sd0, 0);
    push_word(25'd0, 48'sd0, 25'd0, 48'sd0, 1);
    queued = 15;
    drain();

    leaf_set = '{25'd256, 25'd1, 25'd16777216, 25'd1, 25'd4096, 25'd16, 25'd65536, 25'd1};
    leaf_set[5] = CNT_W'($urandom_range(2, 64));
    phase_items = (ITEM_BUDGET - queued) / 8;
    for (int p = 0; p < 8; p++) begin
      int n;
      write_min_leaf(leaf_set[p]);
      if (p == 7) no_idle = 1;
      n = 0;
      // A histogram longer than the bin limit once, with the smallest minimum.
      if (p == 3) begin
        add_histogram(300, 0);
        n += 300;
      end
      while (n < phase_items) begin
        int nb;
        nb = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 10);
        add_histogram(nb, $urandom_range(0, 7) == 0);
        n += nb;
      end
      drain();
    end

    if (errors == 0 && expected_splits.size() == 0) begin
      $display("histogram_best_split_search test passed");
    end else begin
      $display("histogram_best_split_search test failed");
    end
    $finish;
  end

endmodule

[histogram_best_split_search.f]
design/hbs_pkg.sv
design/hbs_in_if.sv
design/hbs_out_if.sv
design/hbs_term.sv
design/hbs_queue.sv
design/hbs_front.sv
design/hbs_back.sv
design/histogram_best_split_search.sv
verif/tb_histogram_best_split_search.sv
